FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// pre implies con in the same cycle
`define ASSERT_IMPLIES(label, pre, con, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (con)) \
    else $error(msg);

// pre implies con in the following cycle
`define ASSERT_NEXT(label, pre, con, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (con)) \
    else $error(msg);

`endif

FILE: design/lap_pkg.sv
// ----------------------------------------------------------------------------
// lap_pkg
// Constants, register codes and item types of the Laplacian stencil block.
// ----------------------------------------------------------------------------
package lap_pkg;

  localparam int unsigned MAX_WIDTH     = 1024;
  localparam int unsigned MAX_HEIGHT    = 1024;
  localparam int unsigned PIXEL_BITS    = 16;
  localparam int unsigned COL_BITS      = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_BITS      = $clog2(MAX_HEIGHT);
  localparam int unsigned CFG_SIZE_BITS = 11;
  localparam int unsigned SIZE_RESET    = 1024;
  localparam int unsigned SIG_BITS      = 3;
  // positive part: up to six pixels; negative part: up to six times the center
  localparam int unsigned POS_BITS      = PIXEL_BITS + 3;
  localparam int unsigned SUM_BITS      = POS_BITS + 1;
  localparam int unsigned LAP_BITS      = SUM_BITS + 2 * ((1 << SIG_BITS) - 1);

  localparam int unsigned NUM_REGS      = 4;
  localparam int unsigned REG_IDX_BITS  = $clog2(NUM_REGS);
  localparam int unsigned PADDR_BITS    = REG_IDX_BITS + 2;
  localparam int unsigned APB_DATA_BITS = 32;

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_FRAME_WIDTH,
    REG_FRAME_HEIGHT,
    REG_THREE_D_MODE,
    REG_SIGMA_EXPONENT
  } cfg_reg_e;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] cur_pixel;
    logic [PIXEL_BITS-1:0] prev_slice_pixel;
    logic [PIXEL_BITS-1:0] next_slice_pixel;
  } lap_in_t;

  typedef struct packed {
    logic signed [LAP_BITS-1:0] lap_value;
    logic [COL_BITS-1:0]        out_x;
    logic [ROW_BITS-1:0]        out_y;
    logic                       out_last;
  } lap_out_t;

  // one column of the line store
  typedef struct packed {
    logic [PIXEL_BITS-1:0] mid;
    logic [PIXEL_BITS-1:0] up;
    logic [PIXEL_BITS-1:0] pv;
    logic [PIXEL_BITS-1:0] nx;
  } lap_entry_t;

  typedef struct packed {
    logic                rd_en;
    logic [COL_BITS-1:0] rd_addr_a;
    logic [COL_BITS-1:0] rd_addr_b;
    logic                wr_en;
    logic [COL_BITS-1:0] wr_addr;
    lap_entry_t          wr_data;
  } lap_lb_req_t;

  // stencil operands of one result
  typedef struct packed {
    logic [PIXEL_BITS-1:0] c;
    logic [PIXEL_BITS-1:0] l;
    logic [PIXEL_BITS-1:0] r;
    logic [PIXEL_BITS-1:0] u;
    logic [PIXEL_BITS-1:0] d;
    logic [PIXEL_BITS-1:0] p;
    logic [PIXEL_BITS-1:0] n;
    logic [COL_BITS-1:0]   x;
    logic [ROW_BITS-1:0]   y;
    logic                  last;
  } lap_op_t;

endpackage

FILE: design/lap_line_buf.sv
// ----------------------------------------------------------------------------
// lap_line_buf
// Column line store: one write port, two registered read ports, write forwarding.
// ----------------------------------------------------------------------------
module lap_line_buf (
  input  logic                              clk_i,
  input  lap_pkg::lap_lb_req_t              req_i,
  output lap_pkg::lap_entry_t               ent_a_o,
  output logic [lap_pkg::PIXEL_BITS-1:0]    mid_b_o
);
  import lap_pkg::*;

  lap_entry_t            mem_q [MAX_WIDTH];
  lap_entry_t            rd_a_q;
  logic [PIXEL_BITS-1:0] rd_b_q;
  logic                  fwd_a_q;
  logic                  fwd_b_q;
  lap_entry_t            fwd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_a_q     <= mem_q[req_i.rd_addr_a];
      rd_b_q     <= mem_q[req_i.rd_addr_b].mid;
      // same-cycle write to the read column: take the new data
      fwd_a_q    <= req_i.wr_en && (req_i.wr_addr == req_i.rd_addr_a);
      fwd_b_q    <= req_i.wr_en && (req_i.wr_addr == req_i.rd_addr_b);
      fwd_data_q <= req_i.wr_data;
    end
  end

  assign ent_a_o = fwd_a_q ? fwd_data_q : rd_a_q;
  assign mid_b_o = fwd_b_q ? fwd_data_q.mid : rd_b_q;

endmodule

FILE: design/lap_arith.sv
// ----------------------------------------------------------------------------
// lap_arith
// Three-stage stencil sum: partial sums, difference, sigma shift to output.
// ----------------------------------------------------------------------------
module lap_arith (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           three_d_i,
  input  logic [lap_pkg::SIG_BITS-1:0]   sigma_i,
  input  logic                           op_valid_i,
  output logic                           op_ready_o,
  input  lap_pkg::lap_op_t               op_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output lap_pkg::lap_out_t              out_o
);
  import lap_pkg::*;

  logic                       a_valid_q, b_valid_q, out_valid_q;
  logic                       a_ready, b_ready, o_free;
  logic [POS_BITS-1:0]        a_pos_q, a_neg_q, pos_d, neg_d;
  logic [COL_BITS-1:0]        a_x_q, b_x_q;
  logic [ROW_BITS-1:0]        a_y_q, b_y_q;
  logic                       a_last_q, b_last_q;
  logic signed [SUM_BITS-1:0] b_diff_q;
  logic [LAP_BITS-1:0]        lap_ext;
  lap_out_t                   out_q;

  assign o_free     = !out_valid_q || out_ready_i;
  assign b_ready    = !b_valid_q || o_free;
  assign a_ready    = !a_valid_q || b_ready;
  assign op_ready_o = a_ready;

  always_comb begin
    pos_d = POS_BITS'(op_i.l) + POS_BITS'(op_i.r) + POS_BITS'(op_i.u) + POS_BITS'(op_i.d);
    neg_d = POS_BITS'(op_i.c) << 2;
    if (three_d_i) begin
      pos_d = pos_d + POS_BITS'(op_i.p) + POS_BITS'(op_i.n);
      neg_d = neg_d + (POS_BITS'(op_i.c) << 1);
    end
  end

  assign lap_ext = {{(LAP_BITS - SUM_BITS){b_diff_q[SUM_BITS-1]}}, b_diff_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (a_ready) a_valid_q   <= op_valid_i;
      if (b_ready) b_valid_q   <= a_valid_q;
      if (o_free)  out_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && op_valid_i) begin
      a_pos_q  <= pos_d;
      a_neg_q  <= neg_d;
      a_x_q    <= op_i.x;
      a_y_q    <= op_i.y;
      a_last_q <= op_i.last;
    end
    if (b_ready && a_valid_q) begin
      b_diff_q <= $signed({1'b0, a_pos_q}) - $signed({1'b0, a_neg_q});
      b_x_q    <= a_x_q;
      b_y_q    <= a_y_q;
      b_last_q <= a_last_q;
    end
    if (o_free && b_valid_q) begin
      out_q.lap_value <= lap_ext << {sigma_i, 1'b0};
      out_q.out_x     <= b_x_q;
      out_q.out_y     <= b_y_q;
      out_q.out_last  <= b_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

FILE: design/laplacian_stencil_2d_3d.sv
// ----------------------------------------------------------------------------
// laplacian_stencil_2d_3d
// Streaming 5-point (2D) / 7-point (3D) Laplacian over one slice, lagging a row.
// ----------------------------------------------------------------------------
// Path: an accepted item waits in stage 1; its results go one per cycle, unless
//   the output stalls, through one adder pipe: partial sums, difference, output.
// Throughput: one item per cycle unless the output stalls or an item has several
//   results; final-row items emit up to two (the last item of the slice up to three).
// Reset: registers to defaults (1024 x 1024, 2D, sigma exponent 0), counters and
//   pipeline empty; the line store is not cleared, raster order writes first.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module laplacian_stencil_2d_3d (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // APB-style configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lap_pkg::PADDR_BITS-1:0]      paddr,
  input  logic [lap_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic [lap_pkg::APB_DATA_BITS-1:0]   prdata,
  output logic                                pready,
  // pixel items in raster order
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  lap_pkg::lap_in_t                    in_item_i,
  // result items
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output lap_pkg::lap_out_t                   out_item_o
);
  import lap_pkg::*;

  // result select, one-hot over the pending mask
  localparam logic [2:0] SEL_ABOVE = 3'b001;  // (x, y-1)
  localparam logic [2:0] SEL_LEFT  = 3'b010;  // (x-1, y), final row
  localparam logic [2:0] SEL_SELF  = 3'b100;  // (x, y), end of final row

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [CFG_SIZE_BITS-1:0] frame_width_q, frame_height_q;
  logic                     three_d_q;
  logic [SIG_BITS-1:0]      sigma_q;
  logic                     cfg_wr, size_wr;
  cfg_reg_e                 cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = cfg_reg_e'(paddr[PADDR_BITS-1:2]);
  assign cfg_wr  = psel && penable && pwrite;
  // a new frame size restarts the slice
  assign size_wr = cfg_wr && ((cfg_idx == REG_FRAME_WIDTH) || (cfg_idx == REG_FRAME_HEIGHT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= CFG_SIZE_BITS'(SIZE_RESET);
      frame_height_q <= CFG_SIZE_BITS'(SIZE_RESET);
      three_d_q      <= 1'b0;
      sigma_q        <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_FRAME_WIDTH:    frame_width_q  <= pwdata[CFG_SIZE_BITS-1:0];
        REG_FRAME_HEIGHT:   frame_height_q <= pwdata[CFG_SIZE_BITS-1:0];
        REG_THREE_D_MODE:   three_d_q      <= pwdata[0];
        REG_SIGMA_EXPONENT: sigma_q        <= pwdata[SIG_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_FRAME_WIDTH:    prdata = APB_DATA_BITS'(frame_width_q);
      REG_FRAME_HEIGHT:   prdata = APB_DATA_BITS'(frame_height_q);
      REG_THREE_D_MODE:   prdata = APB_DATA_BITS'(three_d_q);
      REG_SIGMA_EXPONENT: prdata = APB_DATA_BITS'(sigma_q);
      default:            prdata = '0;
    endcase
  end

  // Effective last column / row: zero acts as one, oversize clamps to the max.
  logic [COL_BITS-1:0] last_col;
  logic [ROW_BITS-1:0] last_row;

  always_comb begin
    if (frame_width_q == '0) begin
      last_col = '0;
    end else if (32'(frame_width_q) > MAX_WIDTH) begin
      last_col = COL_BITS'(MAX_WIDTH - 1);
    end else begin
      last_col = COL_BITS'(32'(frame_width_q) - 1);
    end
    if (frame_height_q == '0) begin
      last_row = '0;
    end else if (32'(frame_height_q) > MAX_HEIGHT) begin
      last_row = ROW_BITS'(MAX_HEIGHT - 1);
    end else begin
      last_row = ROW_BITS'(32'(frame_height_q) - 1);
    end
  end

  // --------------------------------------------------------------------------
  // Raster position of the next item
  // --------------------------------------------------------------------------
  logic [COL_BITS-1:0] col_q, col_d;
  logic [ROW_BITS-1:0] row_q, row_d;
  logic                in_fire;

  assign in_fire = in_valid_i && in_ready_o;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (size_wr) begin
      col_d = '0;
      row_d = '0;
    end else if (in_fire) begin
      if (col_q == last_col) begin
        col_d = '0;
        row_d = (row_q == last_row) ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: item plus its line-store columns (x and x+1), read in the accept
  // cycle. The item stays here until each pending result has gone to the
  // adder pipe; its column is written back as it leaves.
  // --------------------------------------------------------------------------
  logic                  s1_valid_q, s1_valid_d;
  logic [2:0]            s1_pend_q, s1_pend_d;
  logic [COL_BITS-1:0]   s1_x_q;
  logic [ROW_BITS-1:0]   s1_y_q;
  logic [PIXEL_BITS-1:0] s1_cur_q, s1_pv_q, s1_nx_q;
  logic                  s1_x_first_q, s1_x_one_q, s1_x_last_q;
  logic                  s1_y_first_q, s1_y_one_q;
  logic [2:0]            pend_new, sel, pend_left;
  logic                  op_valid, op_ready, op_fire, s1_retire;
  lap_op_t               op;

  lap_lb_req_t           lb_req;
  lap_entry_t            ent_a;
  logic [PIXEL_BITS-1:0] mid_b;

  // previous item of the row: row y at x-1 and x-2, row y-1 at x-1
  logic [PIXEL_BITS-1:0] win_cur1_q, win_cur2_q, win_pv1_q, win_nx1_q, win_mid1_q;

  logic final_row_in;
  assign final_row_in = (row_q == last_row);
  assign pend_new = {final_row_in && (col_q == last_col),
                     final_row_in && (col_q != '0),
                     row_q != '0};

  assign sel       = s1_pend_q & (~s1_pend_q + 1'b1);
  assign pend_left = s1_pend_q & ~sel;
  assign op_valid  = s1_valid_q && (s1_pend_q != '0);
  assign op_fire   = op_valid && op_ready;
  assign s1_retire = s1_valid_q && ((s1_pend_q == '0) || (op_fire && (pend_left == '0)));
  assign in_ready_o = !s1_valid_q || s1_retire;

  always_comb begin
    s1_valid_d = s1_valid_q;
    s1_pend_d  = s1_pend_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
      s1_pend_d  = pend_new;
    end else if (s1_retire) begin
      s1_valid_d = 1'b0;
      s1_pend_d  = '0;
    end else if (op_fire) begin
      s1_pend_d  = pend_left;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_pend_q  <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s1_pend_q  <= s1_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_x_q       <= col_q;
      s1_y_q       <= row_q;
      s1_cur_q     <= in_item_i.cur_pixel;
      s1_pv_q      <= in_item_i.prev_slice_pixel;
      s1_nx_q      <= in_item_i.next_slice_pixel;
      s1_x_first_q <= (col_q == '0);
      s1_x_one_q   <= (col_q == COL_BITS'(1));
      s1_x_last_q  <= (col_q == last_col);
      s1_y_first_q <= (row_q == '0);
      s1_y_one_q   <= (row_q == ROW_BITS'(1));
    end
    if (s1_retire) begin
      win_cur1_q <= s1_cur_q;
      win_cur2_q <= win_cur1_q;
      win_pv1_q  <= s1_pv_q;
      win_nx1_q  <= s1_nx_q;
      win_mid1_q <= ent_a.mid;
    end
  end

  // Line store: read columns x and x+1 on accept, write column x on retire.
  always_comb begin
    lb_req.rd_en       = in_fire;
    lb_req.rd_addr_a   = col_q;
    lb_req.rd_addr_b   = col_q + 1'b1;
    lb_req.wr_en       = s1_retire;
    lb_req.wr_addr     = s1_x_q;
    lb_req.wr_data.mid = s1_cur_q;
    lb_req.wr_data.up  = ent_a.mid;
    lb_req.wr_data.pv  = s1_pv_q;
    lb_req.wr_data.nx  = s1_nx_q;
  end

  lap_line_buf u_line_buf (
    .clk_i   (clk_i),
    .req_i   (lb_req),
    .ent_a_o (ent_a),
    .mid_b_o (mid_b)
  );

  // Operand selection; edge neighbors replicate the center.
  always_comb begin
    op      = '0;
    op.last = (pend_left == '0);
    case (sel)
      SEL_ABOVE: begin
        op.c = ent_a.mid;
        op.l = s1_x_first_q ? ent_a.mid : win_mid1_q;
        op.r = s1_x_last_q  ? ent_a.mid : mid_b;
        op.u = s1_y_one_q   ? ent_a.mid : ent_a.up;
        op.d = s1_cur_q;
        op.p = ent_a.pv;
        op.n = ent_a.nx;
        op.x = s1_x_q;
        op.y = s1_y_q - 1'b1;
      end
      SEL_LEFT: begin
        op.c = win_cur1_q;
        op.l = s1_x_one_q   ? win_cur1_q : win_cur2_q;
        op.r = s1_cur_q;
        op.u = s1_y_first_q ? win_cur1_q : win_mid1_q;
        op.d = win_cur1_q;
        op.p = win_pv1_q;
        op.n = win_nx1_q;
        op.x = s1_x_q - 1'b1;
        op.y = s1_y_q;
      end
      SEL_SELF: begin
        op.c = s1_cur_q;
        op.l = s1_x_first_q ? s1_cur_q : win_cur1_q;
        op.r = s1_cur_q;
        op.u = s1_y_first_q ? s1_cur_q : ent_a.mid;
        op.d = s1_cur_q;
        op.p = s1_pv_q;
        op.n = s1_nx_q;
        op.x = s1_x_q;
        op.y = s1_y_q;
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Shared adder pipe and output register
  // --------------------------------------------------------------------------
  lap_arith u_arith (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .three_d_i   (three_d_q),
    .sigma_i     (sigma_q),
    .op_valid_i  (op_valid),
    .op_ready_o  (op_ready),
    .op_i        (op),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_item_o)
  );

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `ASSERT_ALWAYS(a_pos_in_frame, (col_q <= last_col) && (row_q <= last_row),
                 "raster position outside the frame")
  `ASSERT_NEXT(a_item_held, op_fire && !s1_retire,
               s1_valid_q && $stable(s1_x_q) && $stable(s1_y_q),
               "item left stage 1 with results pending")
  `ASSERT_NEXT(a_row_steady, in_fire && !size_wr && (col_q != last_col), $stable(row_q),
               "row advanced before the end of a row")
  `ASSERT_IMPLIES(a_stall_cause, !in_ready_o, s1_valid_q && (s1_pend_q != '0),
                  "input stalled with no result pending")

endmodule

FILE: tb/lap_stencil_checker.sv
// ----------------------------------------------------------------------------
// lap_stencil_checker
// Watches the config port and both item channels of the Laplacian stencil,
// predicts every result from its own copy of the line stores, compares in order.
// ----------------------------------------------------------------------------
module lap_stencil_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic                              pready,
  input  logic [lap_pkg::PADDR_BITS-1:0]    paddr,
  input  logic [lap_pkg::APB_DATA_BITS-1:0] pwdata,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  lap_pkg::lap_in_t                  in_item_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  lap_pkg::lap_out_t                 out_item_i,
  output int                                pending_o,
  output int                                fail_count_o
);
  import lap_pkg::*;

  logic [CFG_SIZE_BITS-1:0] frame_w = CFG_SIZE_BITS'(SIZE_RESET);
  logic [CFG_SIZE_BITS-1:0] frame_h = CFG_SIZE_BITS'(SIZE_RESET);
  logic                     three_d = 1'b0;
  logic [SIG_BITS-1:0]      sigma_exp = '0;

  logic [PIXEL_BITS-1:0] upper_row [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] mid_row   [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] prev_row  [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] next_row  [MAX_WIDTH];
  int unsigned col_cnt = 0;
  int unsigned row_cnt = 0;

  lap_out_t awaited_lap_q [$];
  int fails = 0;

  // neighbours minus weighted center, plus z term in 3D, shifted left by twice the sigma exponent
  function automatic logic signed [LAP_BITS-1:0] scaled_lap(
    input logic [PIXEL_BITS-1:0] c, l, r, u, d, p, n);
    longint s;
    s = longint'(l) + longint'(r) + longint'(u) + longint'(d) - 4 * longint'(c);
    if (three_d)
      s += longint'(p) + longint'(n) - 2 * longint'(c);
    s = s <<< (2 * sigma_exp);
    return s[LAP_BITS-1:0];
  endfunction

  function automatic lap_out_t make_result(input logic signed [LAP_BITS-1:0] v,
                                           input int unsigned x, y);
    lap_out_t r;
    r.lap_value = v;
    r.out_x     = x[COL_BITS-1:0];
    r.out_y     = y[ROW_BITS-1:0];
    r.out_last  = 1'b0;
    return r;
  endfunction

  task automatic predict_stencil(input lap_in_t px);
    lap_out_t made [$];
    int unsigned w, h, x, y;
    logic [PIXEL_BITS-1:0] c, l, r, u;
    w = (frame_w == 0) ? 1 : frame_w;
    h = (frame_h == 0) ? 1 : frame_h;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    if (col_cnt >= w) col_cnt = 0;
    if (row_cnt >= h) row_cnt = 0;
    x = col_cnt;
    y = row_cnt;

    // result for the pixel one row up
    if (y >= 1) begin
      c = mid_row[x];
      l = (x == 0) ? c : upper_row[x-1];
      r = (x + 1 >= w) ? c : mid_row[x+1];
      u = (y == 1) ? c : upper_row[x];
      made.push_back(make_result(scaled_lap(c, l, r, u, px.cur_pixel, prev_row[x],
                                            next_row[x]), x, y - 1));
    end

    upper_row[x] = mid_row[x];
    mid_row[x]   = px.cur_pixel;
    prev_row[x]  = px.prev_slice_pixel;
    next_row[x]  = px.next_slice_pixel;

    // final row: left neighbour now complete, last column drains itself
    if (y + 1 >= h) begin
      if (x >= 1) begin
        c = mid_row[x-1];
        l = (x == 1) ? c : mid_row[x-2];
        u = (y >= 1) ? upper_row[x-1] : c;
        made.push_back(make_result(scaled_lap(c, l, px.cur_pixel, u, c, prev_row[x-1],
                                              next_row[x-1]), x - 1, y));
      end
      if (x + 1 >= w) begin
        l = (x == 0) ? px.cur_pixel : mid_row[x-1];
        u = (y >= 1) ? upper_row[x] : px.cur_pixel;
        made.push_back(make_result(scaled_lap(px.cur_pixel, l, px.cur_pixel, u,
                                              px.cur_pixel, px.prev_slice_pixel,
                                              px.next_slice_pixel), x, y));
      end
    end

    if (made.size() > 0) made[made.size()-1].out_last = 1'b1;
    foreach (made[i]) awaited_lap_q.push_back(made[i]);

    col_cnt = x + 1;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt = y + 1;
      if (row_cnt >= h) row_cnt = 0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    lap_out_t want;
    if (!rst_ni) begin
      frame_w   = CFG_SIZE_BITS'(SIZE_RESET);
      frame_h   = CFG_SIZE_BITS'(SIZE_RESET);
      three_d   = 1'b0;
      sigma_exp = '0;
      col_cnt   = 0;
      row_cnt   = 0;
      awaited_lap_q.delete();
      fails = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (awaited_lap_q.size() == 0) begin
          if (fails < 10)
            $display("unexpected result: lap=%0d x=%0d y=%0d last=%0b",
                     out_item_i.lap_value, out_item_i.out_x, out_item_i.out_y,
                     out_item_i.out_last);
          fails++;
        end else begin
          want = awaited_lap_q.pop_front();
          if (out_item_i.lap_value !== want.lap_value || out_item_i.out_x !== want.out_x ||
              out_item_i.out_y !== want.out_y || out_item_i.out_last !== want.out_last) begin
            if (fails < 10)
              $display({"mismatch: exp lap=%0d x=%0d y=%0d last=%0b, ",
                        "got lap=%0d x=%0d y=%0d last=%0b"},
                       want.lap_value, want.out_x, want.out_y, want.out_last,
                       out_item_i.lap_value, out_item_i.out_x, out_item_i.out_y,
                       out_item_i.out_last);
            fails++;
          end
        end
      end

      if (in_valid_i && in_ready_i)
        predict_stencil(in_item_i);

      if (psel && penable && pwrite && pready) begin
        case (cfg_reg_e'(paddr[PADDR_BITS-1:2]))
          REG_FRAME_WIDTH: begin
            frame_w = pwdata[CFG_SIZE_BITS-1:0];
            col_cnt = 0;
            row_cnt = 0;
          end
          REG_FRAME_HEIGHT: begin
            frame_h = pwdata[CFG_SIZE_BITS-1:0];
            col_cnt = 0;
            row_cnt = 0;
          end
          REG_THREE_D_MODE:   three_d = pwdata[0];
          REG_SIGMA_EXPONENT: sigma_exp = pwdata[SIG_BITS-1:0];
          default: ;
        endcase
      end

      pending_o    <= awaited_lap_q.size();
      fail_count_o <= fails;
    end
  end

endmodule

FILE: tb/laplacian_stencil_2d_3d_tb.sv
// ----------------------------------------------------------------------------
// laplacian_stencil_2d_3d_tb
// Drives pixel slices through the stencil block under sender bursts and
// receiver stalls, reconfigures between slices, and takes the verdict from
// the checker that sits beside the block.
// ----------------------------------------------------------------------------
module laplacian_stencil_2d_3d_tb;
  import lap_pkg::*;

  // receiver back-pressure patterns
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  localparam int unsigned DRAIN_CYCLES = 8;    // pad past the block's pipeline registers
  localparam int unsigned ITEMS        = 230;  // input items over the whole run

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                     psel    = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite  = 1'b0;
  logic [PADDR_BITS-1:0]    paddr   = '0;
  logic [APB_DATA_BITS-1:0] pwdata  = '0;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  lap_in_t  in_item_i  = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  lap_out_t out_item_o;

  int lap_pending;
  int lap_fails;

  // sender burst state: items left before the next possible gap
  int unsigned burst_left = 0;
  int unsigned items_sent = 0;

  // receiver stall state
  stall_mode_e stall_mode = STALL_NONE;
  int unsigned mode_left  = 0;
  int unsigned tick_cnt   = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  laplacian_stencil_2d_3d i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  lap_stencil_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_item_i    (in_item_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_i   (out_item_o),
    .pending_o    (lap_pending),
    .fail_count_o (lap_fails)
  );

  // Receiver: new random stall pattern when the old one runs out. STALL_NONE gives
  // stretches of full throughput, the others push back on the final-row bursts.
  always @(posedge clk_i) begin
    tick_cnt <= tick_cnt + 1;
    if (mode_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      mode_left  <= $urandom_range(20, 120);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      STALL_NONE:   out_ready_i <= 1'b1;
      STALL_LIGHT:  out_ready_i <= ($urandom_range(0, 3) != 0);
      STALL_HEAVY:  out_ready_i <= ($urandom_range(0, 3) == 0);
      default:      out_ready_i <= (tick_cnt % 5 != 0);
    endcase
  end

  // Pixel values lean on the extremes so every bit sees both levels and the
  // largest positive and negative sums come up often.
  function automatic logic [PIXEL_BITS-1:0] pick_level();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return PIXEL_BITS'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic lap_in_t pix(input logic [PIXEL_BITS-1:0] c, p, n);
    lap_in_t v;
    v.cur_pixel        = c;
    v.prev_slice_pixel = p;
    v.next_slice_pixel = n;
    return v;
  endfunction

  // Sends one item on the input channel; called just after the clock rises. A new
  // burst may open with a random idle gap, which about a third of bursts skip.
  task automatic send_pixel(input lap_in_t px);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 2) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
    burst_left--;
    items_sent++;
    in_valid_i <= 1'b1;
    in_item_i  <= px;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_random(input int unsigned count);
    repeat (count) send_pixel(pix(pick_level(), pick_level(), pick_level()));
  endtask

  // APB write: setup cycle, then access until pready. psel is left high so
  // back-to-back writes do not toggle it within one step.
  task automatic write_reg(input cfg_reg_e idx, input logic [APB_DATA_BITS-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  // Size writes always go first: they restart the slice counters.
  task automatic set_frame(input int unsigned w, h, input bit mode, input int unsigned sig,
                           input bit wr_mode, wr_sig);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    if (wr_mode) write_reg(REG_THREE_D_MODE, APB_DATA_BITS'(mode));
    if (wr_sig)  write_reg(REG_SIGMA_EXPONENT, sig);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Quiesce: the checker count is registered, so step the clock before polling.
  // Row-0 items give no result unless the slice has one row, so pad past the pipe depth afterwards.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (lap_pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned w, h, area, count;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // 4x3 in 2D, unscaled: checkerboard rows and a few single-bit patterns
    set_frame(4, 3, 1'b0, 0, 1'b1, 1'b1);
    send_pixel(pix(16'h0000, 16'hFFFF, 16'hFFFF));
    send_pixel(pix(16'hFFFF, 16'h0000, 16'h0000));
    send_pixel(pix(16'h0000, 16'h1234, 16'h8000));
    send_pixel(pix(16'hFFFF, 16'h7FFF, 16'h0001));
    send_pixel(pix(16'hFFFF, 16'hAAAA, 16'h5555));
    send_pixel(pix(16'h0000, 16'h5555, 16'hAAAA));
    send_pixel(pix(16'hFFFF, 16'h0000, 16'hFFFF));
    send_pixel(pix(16'h0000, 16'hFFFF, 16'h0000));
    send_pixel(pix(16'h5555, 16'h0F0F, 16'hF0F0));
    send_pixel(pix(16'hAAAA, 16'hF0F0, 16'h0F0F));
    send_pixel(pix(16'h0001, 16'h8000, 16'h0001));
    send_pixel(pix(16'h8000, 16'h0001, 16'h8000));
    wait_idle();

    // 3x2 in 3D at the largest scale: center 0 among full-scale neighbours
    // and the reverse give the extreme results
    set_frame(3, 2, 1'b1, 7, 1'b1, 1'b1);
    send_pixel(pix(16'h0000, 16'hFFFF, 16'hFFFF));
    send_pixel(pix(16'hFFFF, 16'h0000, 16'h0000));
    send_pixel(pix(16'h0000, 16'hFFFF, 16'hFFFF));
    send_pixel(pix(16'hFFFF, 16'h0000, 16'h0000));
    send_pixel(pix(16'h0000, 16'hFFFF, 16'hFFFF));
    send_pixel(pix(16'hFFFF, 16'h0000, 16'h0000));
    wait_idle();

    // zero sizes act as 1x1: every item is a whole slice, only the z term left
    set_frame(0, 0, 1'b1, 7, 1'b0, 1'b0);
    send_pixel(pix(16'h0000, 16'hFFFF, 16'hFFFF));
    send_pixel(pix(16'hFFFF, 16'h0000, 16'h0000));
    wait_idle();

    // oversize width acts as a full row: start of a single-row slice
    set_frame(2047, 1, 1'b1, 3, 1'b1, 1'b1);
    send_random(24);
    wait_idle();

    // oversize height with one column: start of a slice, abandoned by the
    // next size write
    set_frame(1, 2047, 1'b0, 5, 1'b1, 1'b1);
    send_random(24);
    wait_idle();

    // random small frames: mostly whole slices, sometimes a cut-off slice
    // that the next size write abandons
    while (items_sent < ITEMS) begin
      w = ($urandom_range(0, 9) == 0) ? 0 :
          ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
      area  = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
      count = area * $urandom_range(1, 2);
      if ($urandom_range(0, 3) == 0) count += $urandom_range(0, area - 1);
      if (count > ITEMS - items_sent) count = ITEMS - items_sent;
      set_frame(w, h, 1'($urandom_range(0, 1)), $urandom_range(0, 7),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      send_random(count);
      wait_idle();
    end

    if (lap_fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin
    #1_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/lap_pkg.sv
design/lap_line_buf.sv
design/lap_arith.sv
design/laplacian_stencil_2d_3d.sv
tb/lap_stencil_checker.sv
tb/laplacian_stencil_2d_3d_tb.sv
